/* rtl/ahsp_pkg.sv */
// Shared constants, types and helpers for the heading sentence parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package ahsp_pkg;

  // Kept decimal fraction digits (output unit is 10^-FRACTION_DIGITS degree).
  localparam int FRACTION_DIGITS = 6;

  localparam longint unsigned POW10 [0:9] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
    64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
  };
  localparam longint unsigned POW_SCALE = POW10[FRACTION_DIGITS];

  // Any integer part at or above this saturates the output either way.
  localparam longint unsigned INT_LIMIT = 64'h8000_0000 / POW_SCALE + 64'd1;
  localparam int INT_W     = $clog2(INT_LIMIT + 64'd1);
  localparam int FRAC_W    = $clog2(POW_SCALE);
  localparam int CNT_W     = $clog2(FRACTION_DIGITS + 1);
  localparam int MAG_W     = 34;
  localparam int POW_IDX_W = $clog2(10);

  localparam logic [31:0] EMPTY_VALUE = 32'(~POW_SCALE + 64'd1);
  localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;

  // ASCII characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Operations passed from front to back
  localparam logic [1:0] OP_START = 2'd0;  // clear number, hit marks target field
  localparam logic [1:0] OP_OPEN  = 2'd1;  // frame opened by the start pair
  localparam logic [1:0] OP_DATA  = 2'd2;  // byte inside the target field
  localparam logic [1:0] OP_EMIT  = 2'd3;  // frame closed, deliver result

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic [7:0] data;
  } ahsp_op_t;

  // Weight of the next kept fraction digit; valid only while cnt < FRACTION_DIGITS.
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
    logic [POW_IDX_W-1:0] idx;
    idx = POW_IDX_W'(FRACTION_DIGITS - 1) - POW_IDX_W'(cnt);
    return FRAC_W'(POW10[idx]);
  endfunction

endpackage

/* rtl/ahsp_front.sv */
// Front end: frame hunting, field counting and byte classification.
// Depends on ahsp_pkg; pushes operations into ahsp_queue.
module ahsp_front import ahsp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     field_index,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           queue_full,
  output logic           push,
  output ahsp_op_t       push_op
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HASH = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_CR   = 2'd3;
  localparam logic [4:0] CNT_MAX = 5'd31;

  logic [1:0] phase, phase_next;
  logic [4:0] counter, counter_next;
  logic       semi, semi_next;
  logic       accept;
  logic [4:0] index_ext;
  logic [4:0] counter_inc;

  assign in_stall    = queue_full;
  assign accept      = in_valid && !queue_full;
  assign index_ext   = {1'b0, field_index};
  assign counter_inc = (counter == CNT_MAX) ? counter : counter + 5'd1;

  always_comb begin
    phase_next   = phase;
    counter_next = counter;
    semi_next    = semi;
    push         = 1'b0;
    push_op.op   = OP_DATA;
    push_op.hit  = 1'b0;
    push_op.data = in_byte;
    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (in_byte == CH_HASH) phase_next = PH_HASH;
        end
        PH_HASH: begin
          if (in_byte == CH_H) begin
            counter_next = 5'd0;
            semi_next    = 1'b0;
            push         = 1'b1;
            push_op.op   = OP_OPEN;
            push_op.hit  = (field_index == 4'd0);
            phase_next   = PH_BODY;
          end else if (in_byte != CH_HASH) begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY, PH_CR: begin
          if (phase == PH_CR && in_byte == CH_LF) begin
            push       = 1'b1;
            push_op.op = OP_EMIT;
            phase_next = PH_HUNT;
          end else begin
            if (in_byte == CH_COMMA) begin
              counter_next = counter_inc;
              if (counter_inc == index_ext) begin
                push        = 1'b1;
                push_op.op  = OP_START;
                push_op.hit = 1'b1;
              end
            end else if (in_byte == CH_SEMI && !semi) begin
              // first semicolon restarts field numbering and drops any number
              semi_next    = 1'b1;
              counter_next = 5'd0;
              push         = 1'b1;
              push_op.op   = OP_START;
              push_op.hit  = (field_index == 4'd0);
            end else if (counter == index_ext) begin
              push = 1'b1;
            end
            phase_next = (in_byte == CH_CR) ? PH_CR : PH_BODY;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      counter <= 5'd0;
      semi    <= 1'b0;
    end else begin
      phase   <= phase_next;
      counter <= counter_next;
      semi    <= semi_next;
    end
  end

endmodule

/* rtl/ahsp_queue.sv */
// Short FIFO of classified operations between front and back.
// Depends on ahsp_pkg for the entry type and depth.
module ahsp_queue import ahsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ahsp_op_t  push_op,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output ahsp_op_t  head_op
);

  ahsp_op_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/ahsp_back.sv */
// Back end: decimal number accumulation for the target field and result register.
// Depends on ahsp_pkg; pops operations from ahsp_queue.
module ahsp_back import ahsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ahsp_op_t           head_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] heading_micro_deg,
  output logic [1:0]         parse_status
);

  logic [INT_W-1:0]  int_acc, int_acc_next;
  logic [FRAC_W-1:0] frac_acc, frac_acc_next;
  logic [CNT_W-1:0]  frac_cnt, frac_cnt_next;
  logic f_neg, f_dot, f_stop, f_present, f_nonempty;
  logic f_neg_next, f_dot_next, f_stop_next, f_present_next, f_nonempty_next;

  logic              is_digit;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_prod;
  logic [FRAC_W+3:0] frac_add;
  logic [MAG_W-1:0]  mag;
  logic [31:0]       emit_value;
  logic [1:0]        emit_status;
  logic              emit;

  assign pop      = head_valid && (head_op.op != OP_EMIT || !out_valid || !out_stall);
  assign emit     = pop && head_op.op == OP_EMIT;
  assign is_digit = head_op.data >= CH_ZERO && head_op.data <= CH_NINE;
  assign digit    = 4'(head_op.data - CH_ZERO);
  assign int_prod = (INT_W+4)'(int_acc) * (INT_W+4)'(10) + (INT_W+4)'(digit);
  assign frac_add = (FRAC_W+4)'(frac_acc)
                  + (FRAC_W+4)'(digit) * (FRAC_W+4)'(frac_weight(frac_cnt));
  assign mag      = MAG_W'(int_acc) * MAG_W'(POW_SCALE) + MAG_W'(frac_acc);

  always_comb begin
    int_acc_next    = int_acc;
    frac_acc_next   = frac_acc;
    frac_cnt_next   = frac_cnt;
    f_neg_next      = f_neg;
    f_dot_next      = f_dot;
    f_stop_next     = f_stop;
    f_present_next  = f_present;
    f_nonempty_next = f_nonempty;
    if (pop) begin
      case (head_op.op)
        OP_START, OP_OPEN: begin
          int_acc_next    = '0;
          frac_acc_next   = '0;
          frac_cnt_next   = '0;
          f_neg_next      = 1'b0;
          f_dot_next      = 1'b0;
          f_present_next  = head_op.hit;
          // the start pair itself lands in field zero and stops the parse
          f_stop_next     = head_op.hit && head_op.op == OP_OPEN;
          f_nonempty_next = head_op.hit && head_op.op == OP_OPEN;
        end
        OP_DATA: begin
          if (f_present) begin
            f_nonempty_next = 1'b1;
            if (!f_stop) begin
              if (is_digit) begin
                if (f_dot) begin
                  if (frac_cnt < CNT_W'(FRACTION_DIGITS)) begin
                    frac_acc_next = FRAC_W'(frac_add);
                    frac_cnt_next = frac_cnt + CNT_W'(1);
                  end
                end else if (int_prod > (INT_W+4)'(INT_LIMIT)) begin
                  int_acc_next = INT_W'(INT_LIMIT);
                end else begin
                  int_acc_next = INT_W'(int_prod);
                end
              end else if (!f_nonempty && head_op.data == CH_MINUS) begin
                f_neg_next = 1'b1;
              end else if (!f_nonempty && head_op.data == CH_PLUS) begin
                f_neg_next = f_neg;
              end else if (head_op.data == CH_DOT && !f_dot) begin
                f_dot_next = 1'b1;
              end else begin
                f_stop_next = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!f_present) begin
      emit_value  = 32'd0;
      emit_status = ST_ABSENT;
    end else if (!f_nonempty) begin
      emit_value  = EMPTY_VALUE;
      emit_status = ST_EMPTY;
    end else if (f_neg) begin
      emit_value  = (mag > MAG_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      emit_status = ST_OK;
    end else begin
      emit_value  = (mag > MAG_W'(POS_MAX)) ? POS_MAX : mag[31:0];
      emit_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_cnt   <= '0;
      f_neg      <= 1'b0;
      f_dot      <= 1'b0;
      f_stop     <= 1'b0;
      f_present  <= 1'b0;
      f_nonempty <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      frac_cnt   <= frac_cnt_next;
      f_neg      <= f_neg_next;
      f_dot      <= f_dot_next;
      f_stop     <= f_stop_next;
      f_present  <= f_present_next;
      f_nonempty <= f_nonempty_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      heading_micro_deg <= signed'(emit_value);
      parse_status      <= emit_status;
    end
  end

endmodule

/* rtl/ascii_heading_sentence_parser_top.sv */
// Top level of the ASCII heading sentence parser: register port and module wiring.
// Depends on ahsp_pkg, ahsp_front, ahsp_queue and ahsp_back.
//
//   channel   direction  handshake             payload
//   ------------------------------------------------------------------------
//   input     in         in_valid / in_stall   in_byte[7:0]
//   result    out        out_valid / out_stall heading_micro_deg[31:0], parse_status[1:0]
//   config    in         psel/penable/pwrite   paddr[2:0], pwdata/prdata[31:0]
//
// One byte is accepted per cycle while in_stall is low. The front classifies each byte
// against the frame state in the cycle it is accepted; the back consumes one classified
// item per cycle from a two-entry queue unless a held result stalls it at a frame end.
// The result register is the only point where out_stall pushes back; a held result
// stalls the back only on the next frame end, and the queue then fills before in_stall.
// Synchronous reset clears frame state, number state, queue and valid flags;
// field_index resets to 3. No clearing pass is needed.
module ascii_heading_sentence_parser_top import ahsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // byte stream
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  // parsed heading
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] heading_micro_deg,
  output logic [1:0]         parse_status,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register map: field_index at byte addresses 0 to 3 (only paddr[2] is decoded)
  localparam logic       REG_FIELD_INDEX   = 1'b0;
  localparam logic [3:0] FIELD_INDEX_RESET = 4'd3;

  logic [3:0] field_index;
  logic       reg_write;
  logic       q_push, q_full, q_pop, q_head_valid;
  ahsp_op_t   q_push_op, q_head_op;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  // Write only the target field index, decoded from paddr[2]; addresses 4 to 7 are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= FIELD_INDEX_RESET;
    end else if (reg_write && paddr[2] == REG_FIELD_INDEX) begin
      field_index <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_FIELD_INDEX) ? {28'd0, field_index} : 32'd0;

  // Front: hunt the start pair, count fields, classify bytes.
  ahsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .field_index (field_index),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .queue_full  (q_full),
    .push        (q_push),
    .push_op     (q_push_op)
  );

  // Decouple the two halves so a held result does not stall input at once.
  ahsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // Back: accumulate the target field's number and deliver the result.
  ahsp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (q_head_valid),
    .head_op           (q_head_op),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .heading_micro_deg (heading_micro_deg),
    .parse_status      (parse_status)
  );

endmodule

/* tb/heading_parse_checker.sv */
// Checker for the heading sentence parser: watches the byte, result and register channels.
// Predicts each result from the accepted bytes and compares it field by field.
// Depends on ahsp_pkg for character codes, status codes and the fraction scale.
module heading_parse_checker import ahsp_pkg::*; #(
  parameter logic [2:0] ADDR_FIELD_INDEX = 3'd0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] heading_micro_deg,
  input  logic [1:0]         parse_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 headings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] FIELD_INDEX_RESET = 4'd3;

  typedef enum logic [1:0] {HUNT_HASH, HASH_SEEN, IN_FRAME, AFTER_CR} frame_phase_t;

  typedef struct {
    logic signed [31:0] heading;
    logic [1:0]         status;
  } heading_result_t;

  heading_result_t expected_headings[$];
  int              errors = 0;

  // predicted block state
  logic [3:0]   field_index;
  frame_phase_t phase;
  logic [4:0]   field_no;
  logic         semi_seen;
  logic [31:0]  int_acc;
  logic [31:0]  frac_acc;
  int unsigned  frac_cnt;
  logic         negative, dot_seen, stopped, present, nonempty;

  task automatic clear_number();
    int_acc  = '0;
    frac_acc = '0;
    frac_cnt = 0;
    {negative, dot_seen, stopped, present, nonempty} = '0;
  endtask

  task automatic reset_model();
    field_index = FIELD_INDEX_RESET;
    phase       = HUNT_HASH;
    field_no    = '0;
    semi_seen   = 1'b0;
    clear_number();
    expected_headings.delete();
  endtask

  task automatic open_field();
    if (field_no == 5'(field_index)) begin
      clear_number();
      present = 1'b1;
    end
  endtask

  // Accumulate one byte of the heading field; anything outside a number stops parsing.
  task automatic number_byte(input logic [7:0] c);
    logic            first;
    longint unsigned wide;
    if (!present || field_no != 5'(field_index)) return;
    first    = !nonempty;
    nonempty = 1'b1;
    if (stopped) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (dot_seen) begin
        if (frac_cnt < FRACTION_DIGITS) begin
          frac_acc = frac_acc * 32'd10 + 32'(c - CH_ZERO);
          frac_cnt++;
        end
      end else begin
        wide    = 64'(int_acc) * 64'd10 + 64'(c - CH_ZERO);
        int_acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      end
    end else if (first && c == CH_MINUS) begin
      negative = 1'b1;
    end else if (first && c == CH_PLUS) begin
      // sign accepted, nothing to hold
    end else if (c == CH_DOT && !dot_seen) begin
      dot_seen = 1'b1;
    end else begin
      stopped = 1'b1;
    end
  endtask

  task automatic frame_byte(input logic [7:0] c);
    if (c == CH_COMMA) begin
      if (field_no != 5'd31) field_no++;
      open_field();
    end else if (c == CH_SEMI && !semi_seen) begin
      semi_seen = 1'b1;
      field_no  = '0;
      clear_number();
      open_field();
    end else begin
      number_byte(c);
    end
  endtask

  function automatic heading_result_t closing_result();
    heading_result_t r;
    longint unsigned mag;
    if (!present) begin
      r.heading = '0;
      r.status  = ST_ABSENT;
    end else if (!nonempty) begin
      r.heading = 32'(64'd0 - POW10[FRACTION_DIGITS]);
      r.status  = ST_EMPTY;
    end else begin
      mag = 64'(int_acc) * POW10[FRACTION_DIGITS]
          + 64'(frac_acc) * POW10[FRACTION_DIGITS - frac_cnt];
      if (negative) begin
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        r.heading = 32'(64'd0 - mag);
      end else begin
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        r.heading = 32'(mag);
      end
      r.status = ST_OK;
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] c);
    heading_result_t r;
    case (phase)
      HUNT_HASH: if (c == CH_HASH) phase = HASH_SEEN;
      HASH_SEEN: begin
        if (c == CH_H) begin
          field_no  = '0;
          semi_seen = 1'b0;
          clear_number();
          open_field();
          number_byte(CH_HASH);
          number_byte(CH_H);
          phase = IN_FRAME;
        end else if (c != CH_HASH) begin
          phase = HUNT_HASH;
        end
      end
      IN_FRAME: begin
        frame_byte(c);
        if (c == CH_CR) phase = AFTER_CR;
      end
      default: begin
        if (c == CH_LF) begin
          r = closing_result();
          expected_headings = {expected_headings, r};
          phase = HUNT_HASH;
        end else begin
          frame_byte(c);
          phase = (c == CH_CR) ? AFTER_CR : IN_FRAME;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    heading_result_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_FIELD_INDEX)
        field_index = pwdata[3:0];
      if (in_valid && !in_stall) predict_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (expected_headings.size() == 0) begin
          $display("%0t: unexpected result: expected none, got heading %0d status %0d",
                   $time, heading_micro_deg, parse_status);
          errors++;
        end else begin
          want = expected_headings.pop_front();
          if (heading_micro_deg !== want.heading) begin
            $display("%0t: heading_micro_deg mismatch: expected %0d, got %0d",
                     $time, want.heading, heading_micro_deg);
            errors++;
          end
          if (parse_status !== want.status) begin
            $display("%0t: parse_status mismatch: expected %0d, got %0d",
                     $time, want.status, parse_status);
            errors++;
          end
        end
      end
    end
    mismatch_count   <= errors;
    headings_pending <= expected_headings.size();
  end

endmodule

/* tb/ascii_heading_sentence_parser_top_test.sv */
// Testbench top for the heading sentence parser: clock, reset, byte stimulus, register
// writes and the verdict. Depends on ahsp_pkg, the parser RTL and heading_parse_checker.
module ascii_heading_sentence_parser_top_test import ahsp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_FIELD_INDEX = 3'd0;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] heading_micro_deg;
  logic [1:0]         parse_status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = 3'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatch_count;
  int headings_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  // Bytes of the sentence under construction.
  logic [7:0] sentence[$];

  ascii_heading_sentence_parser_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .heading_micro_deg(heading_micro_deg), .parse_status(parse_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  heading_parse_checker #(.ADDR_FIELD_INDEX(ADDR_FIELD_INDEX)) heading_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .heading_micro_deg(heading_micro_deg), .parse_status(parse_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(mismatch_count), .headings_pending(headings_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stall the result channel at random; one assignment per edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item and hold it until accepted. Valid is only dropped while idling,
  // so a back-to-back item never sees valid lowered and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Drop valid, let every expected result drain, then give the back end time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (headings_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the access edge. Upper data
  // bits are random since only the low nibble holds the index.
  task automatic write_field_index(input logic [3:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FIELD_INDEX;
    pwdata  <= ($urandom() & 32'hFFFF_FFF0) | 32'(idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Append one byte to the sentence under construction.
  task automatic add_byte(input logic [7:0] b);
    sentence = {sentence, b};
  endtask

  task automatic add_digits(input int unsigned n);
    repeat (n) add_byte(8'(CH_ZERO + $urandom_range(9)));
  endtask

  // One comma field: mostly numbers of varied shape, some empty, text or raw bytes.
  task automatic add_field();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      if ($urandom_range(3) == 0) add_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
      add_digits(($urandom_range(9) == 0) ? $urandom_range(14) : $urandom_range(1, 4));
      if ($urandom_range(2) != 0) begin
        add_byte(CH_DOT);
        add_digits(($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(7));
      end
      // trailing junk: space, exponent, second dot or any printable byte
      if ($urandom_range(7) == 0) begin
        add_byte(8'($urandom_range(32, 126)));
        add_digits($urandom_range(3));
      end
    end else if (pick < 75) begin
      // leave the field empty
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(65, 90)));
    end else begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
    end
  endtask

  // Build and send one sentence aimed at the given field; most are well formed,
  // some lack the semicolon, carry a stray CR or lose their terminator.
  task automatic send_random_sentence(input int unsigned target);
    int unsigned field_total;
    int unsigned ending;
    logic        with_semi;
    sentence.delete();
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    add_byte(CH_HASH);
    add_byte(CH_H);
    repeat ($urandom_range(3)) add_byte(8'($urandom_range(65, 90)));
    with_semi = ($urandom_range(7) != 0);
    if (with_semi) add_byte(CH_SEMI);
    field_total = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(target + 3);
    for (int unsigned f = 0; f < field_total; f++) begin
      if (f != 0 || !with_semi) add_byte(CH_COMMA);
      add_field();
    end
    ending = $urandom_range(99);
    if (ending >= 6) begin
      if (ending < 14) add_byte(CH_CR);
      if (ending < 10) add_byte(8'($urandom_range(32, 126)));
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    foreach (sentence[i]) send_byte(sentence[i]);
  endtask

  // Random sentences until about the given number of frame bytes went out, then
  // close with a clean sentence so the block ends between frames.
  task automatic run_random(input int unsigned budget, input int unsigned target);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      send_random_sentence(target);
      sent += sentence.size();
    end
    send_line("#H;1,2,3,4");
  endtask

  initial begin
    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed sentences at the reset index (field 3).
    send_idle_pct = 35;
    recv_idle_pct = 47;
    send_line("#HDG,1;a,b,c,359.999999");
    send_line("#H;a,b,c,-12.5");
    send_line("#H;a,b,c,,e");                // empty heading field
    send_line("#H;a,b");                     // heading field absent
    send_line("#H;a,b,c,+7.1234567890");     // surplus fraction digits truncated
    send_line("#H;a,b,c,99999999999");       // integer part saturates
    send_line("#H;a,b,c,-2147.483648");      // exactly the negative limit
    send_line("#H;a,b,c,-9999.9");           // negative saturation
    send_line("#H;a,b,c,2147.483647");       // exactly the positive limit
    send_line("#H;a,b,c,12 34");             // space stops the number
    send_line("#H;a,b,c,1.2.3");             // second dot stops the number
    send_line("#H;a,b,c,1e5,x");             // exponent stops the number
    send_line("#H;a,b,c,+-3");               // sign only allowed as first byte
    send_line("#H;a,b,c,-");                 // sign without digits parses as zero
    send_line("#H;a,b,c,.5");
    send_line("#H,a,b,5");                   // no semicolon: count from the start pair
    send_line("#H;a;b,c,d,6");               // later semicolon is plain data
    send_line("#H;a,#H,c,8");                // start pair inside a frame is plain data
    // lone CR inside the field, then a doubled CR before LF
    send_text("#H;a,b,c,4");
    send_byte(CH_CR);
    send_text("5");
    send_byte(CH_CR);
    send_line("");
    // noise between frames, a false start and a repeated hash before the frame
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_LF);
    send_text("#XH##H;a,b,c,0.000001");
    send_byte(8'hB7);
    send_line("");
    // more commas than the field counter holds: it must saturate, not wrap
    send_text("#H;a,b,c,1.5");
    repeat (36) send_text(",7");
    send_line("");
    settle();

    // Random part, lowest index; sender lighter, receiver heavier idling.
    write_field_index(4'd0);
    run_random(350, 0);
    settle();

    // Highest index, idling swapped.
    write_field_index(4'd15);
    send_idle_pct = 47;
    recv_idle_pct = 35;
    run_random(350, 15);
    settle();

    // No idling on either side, two more settings.
    write_field_index(4'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(125, 2);
    settle();
    begin : last_setting
      logic [3:0] idx;
      idx = 4'($urandom_range(15));
      write_field_index(idx);
      run_random(125, 32'(idx));
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ahsp_pkg.sv
rtl/ahsp_front.sv
rtl/ahsp_queue.sv
rtl/ahsp_back.sv
rtl/ascii_heading_sentence_parser_top.sv
tb/heading_parse_checker.sv
tb/ascii_heading_sentence_parser_top_test.sv
